// ===== hw/rtl/vdi_pkg.sv =====
package vdi_pkg;

  localparam int unsigned TABLE_DEPTH = 1024;
  localparam int unsigned CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned COORD_W     = 32;
  localparam int unsigned KEY_W       = 3 * COORD_W;
  localparam int unsigned VIDX_W      = 11;
  localparam int unsigned SLOT_W      = 2;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [KEY_W-1:0]   key_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [VIDX_W-1:0]  vidx_t;
  typedef logic [SLOT_W-1:0]  slot_t;

  localparam coord_t NEG_ZERO  = {1'b1, {(COORD_W-1){1'b0}}};
  localparam slot_t  SLOT_FIRST = slot_t'(0);
  localparam slot_t  SLOT_LAST  = slot_t'(2);

  typedef struct packed {
    logic  vld;
    key_t  key;
    logic  found;
    logic  is_new;
    cnt_t  index;
    slot_t slot;
  } query_t;

  function automatic coord_t fold_zero(coord_t v);
    return (v == NEG_ZERO) ? coord_t'(0) : v;
  endfunction

  function automatic vidx_t to_vidx(cnt_t v);
    return vidx_t'(v);
  endfunction

endpackage

// ===== hw/rtl/vdi_cell.sv =====
module vdi_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            advance,
  input  vdi_pkg::cnt_t   cell_idx,
  input  vdi_pkg::cnt_t   count,
  input  vdi_pkg::query_t q_in,
  output vdi_pkg::query_t q_out,
  output logic            ins
);

  vdi_pkg::key_t   key_r;
  vdi_pkg::query_t q_r;
  vdi_pkg::query_t q_nxt;
  logic            occupied;
  logic            hit;
  logic            take;

  assign occupied = (cell_idx < count);
  assign hit      = q_in.vld && !q_in.found && occupied && (key_r == q_in.key);
  assign take     = q_in.vld && !q_in.found && (cell_idx == count);
  assign ins      = advance && take;

  always_comb begin
    q_nxt = q_in;
    if (hit || take) begin
      q_nxt.found  = 1'b1;
      q_nxt.is_new = take;
      q_nxt.index  = cell_idx + vdi_pkg::cnt_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ins) begin
      key_r <= q_in.key;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.vld <= 1'b0;
    end else if (advance) begin
      q_r <= q_nxt;
    end
  end

  assign q_out = q_r;

endmodule

// ===== hw/rtl/vertex_dedup_indexer.sv =====
// Vertex welding index table. Each item on the input channel is one triangle
// corner given as three single-precision bit patterns; negative zero is
// treated as positive zero. Each item yields exactly one result item with the
// 1-based index of the matching unique vertex, or of the vertex just stored.
// When the table is full and the corner is new, the index is 0 and overflow
// is set. A corner counter tags each result with its slot in the face.
// Corners travel down a row of TABLE_DEPTH cells, one cell per cycle while
// the row advances; each cell holds one stored vertex, compares it and stores
// a new corner when it is the first free cell. A result is presented from the
// last cell's register once its item has passed all TABLE_DEPTH cells. A new
// item can be accepted in every cycle unless the row is stalled, so throughput
// is one item per cycle when nothing stalls.
// The last cell doubles as the output register. When the receiver stalls a
// waiting result, the whole row holds and in_stall is raised.
// Reset empties the table and clears the corner counter; no clearing pass over
// the stored keys is needed.
module vertex_dedup_indexer (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  vdi_pkg::coord_t      in_vertex_x,
  input  vdi_pkg::coord_t      in_vertex_y,
  input  vdi_pkg::coord_t      in_vertex_z,
  output logic                 out_valid,
  input  logic                 out_stall,
  output vdi_pkg::vidx_t       out_vertex_index,
  output logic                 out_is_new,
  output vdi_pkg::slot_t       out_corner_slot,
  output logic                 out_face_done,
  output logic                 out_overflow
);

  vdi_pkg::query_t                     q [vdi_pkg::TABLE_DEPTH+1];
  vdi_pkg::query_t                     head;
  logic [vdi_pkg::TABLE_DEPTH-1:0]     ins;
  vdi_pkg::cnt_t                       count_r;
  vdi_pkg::cnt_t                       count_nxt;
  vdi_pkg::slot_t                      slot_r;
  vdi_pkg::slot_t                      slot_nxt;
  logic                                advance;
  logic                                in_acc;
  vdi_pkg::query_t                     tail;

  assign tail     = q[vdi_pkg::TABLE_DEPTH];
  assign advance  = !tail.vld || !out_stall;
  assign in_stall = !advance;
  assign in_acc   = in_valid && advance;

  always_comb begin
    head.vld    = in_valid;
    head.key    = {vdi_pkg::fold_zero(in_vertex_x),
                   vdi_pkg::fold_zero(in_vertex_y),
                   vdi_pkg::fold_zero(in_vertex_z)};
    head.found  = 1'b0;
    head.is_new = 1'b0;
    head.index  = vdi_pkg::cnt_t'(0);
    head.slot   = slot_r;
  end

  assign q[0] = head;

  for (genvar i = 0; i < vdi_pkg::TABLE_DEPTH; i++) begin : g_cell
    vdi_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .advance  (advance),
      .cell_idx (vdi_pkg::cnt_t'(i)),
      .count    (count_r),
      .q_in     (q[i]),
      .q_out    (q[i+1]),
      .ins      (ins[i])
    );
  end

  always_comb begin
    count_nxt = count_r;
    if (|ins) begin
      count_nxt = count_r + vdi_pkg::cnt_t'(1);
    end
    slot_nxt = slot_r;
    if (in_acc) begin
      slot_nxt = (slot_r == vdi_pkg::SLOT_LAST) ? vdi_pkg::SLOT_FIRST
                                                : slot_r + vdi_pkg::slot_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= vdi_pkg::cnt_t'(0);
      slot_r  <= vdi_pkg::SLOT_FIRST;
    end else begin
      count_r <= count_nxt;
      slot_r  <= slot_nxt;
    end
  end

  assign out_valid        = tail.vld;
  assign out_vertex_index = vdi_pkg::to_vidx(tail.index);
  assign out_is_new       = tail.is_new;
  assign out_corner_slot  = tail.slot;
  assign out_face_done    = (tail.slot == vdi_pkg::SLOT_LAST);
  assign out_overflow     = !tail.found;

endmodule

// ===== hw/rtl/vdi_checker.sv =====
module vdi_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            in_stall,
  input logic            out_valid,
  input logic            out_stall,
  input vdi_pkg::vidx_t  out_vertex_index,
  input logic            out_is_new,
  input vdi_pkg::slot_t  out_corner_slot,
  input logic            out_face_done,
  input logic            out_overflow
);

  // A stalled result keeps its contents until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_vertex_index)
      && $stable(out_corner_slot) && $stable(out_is_new) && $stable(out_overflow))
    else $error("stalled result changed");

  // The input side only waits while a result is held back by the receiver.
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without an output stall");

  // A corner that could not be stored carries index zero and is not new.
  a_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_overflow |-> out_vertex_index == vdi_pkg::vidx_t'(0) && !out_is_new)
    else $error("overflow result has an index");

  // A stored or matched corner always has a nonzero index.
  a_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_overflow |-> out_vertex_index != vdi_pkg::vidx_t'(0))
    else $error("valid vertex with index zero");

  // The face completes exactly on the last corner slot.
  a_face: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_face_done == (out_corner_slot == vdi_pkg::SLOT_LAST))
      && (out_corner_slot != vdi_pkg::slot_t'(3)))
    else $error("face_done does not follow the corner slot");

endmodule

bind vertex_dedup_indexer vdi_checker u_vdi_checker (.*);

// ===== tb/sv/tb_vertex_dedup_indexer.sv =====
module tb_vertex_dedup_indexer;

  localparam int unsigned     CLK_HALF       = 4;
  localparam int unsigned     RESET_CYCLES   = 9;
  localparam int unsigned     MAX_REPORTS    = 10;
  localparam int unsigned     HOLD_CYCLES    = 4000;
  localparam int unsigned     SETTLE_CYCLES  = vdi_pkg::TABLE_DEPTH + 16;
  localparam int unsigned     TIMEOUT_CYCLES = 400000;
  localparam int unsigned     FILL_NEW_PCT   = 93;
  localparam int unsigned     FULL_NEW_PCT   = 40;
  localparam int unsigned     TAIL_ITEMS     = 60;
  localparam int unsigned     HOLD_AT_ITEM   = 40;
  localparam vdi_pkg::coord_t QUIET_NAN      = 32'h7FC0_0000;
  localparam vdi_pkg::coord_t ONE_F          = 32'h3F80_0000;
  localparam vdi_pkg::coord_t ALL_ONES       = 32'hFFFF_FFFF;

  typedef struct packed {
    vdi_pkg::vidx_t vertex_index;
    logic           is_new;
    vdi_pkg::slot_t corner_slot;
    logic           face_done;
    logic           overflow;
  } corner_result_t;

  class vertex_weld_tracker;
    vdi_pkg::key_t  welded_keys[vdi_pkg::TABLE_DEPTH];
    int unsigned    position_of[vdi_pkg::key_t];
    int unsigned    welded_count;
    vdi_pkg::slot_t next_slot;
    corner_result_t expected_corners[$];
    int unsigned    mismatch_count;

    function new();
      welded_count   = 0;
      next_slot      = vdi_pkg::SLOT_FIRST;
      mismatch_count = 0;
    endfunction

    function vdi_pkg::coord_t canon_coord(vdi_pkg::coord_t v);
      return (v == vdi_pkg::NEG_ZERO) ? vdi_pkg::coord_t'(0) : v;
    endfunction

    function void note_corner(vdi_pkg::coord_t x, vdi_pkg::coord_t y, vdi_pkg::coord_t z);
      vdi_pkg::key_t  k;
      corner_result_t r;
      k = {canon_coord(x), canon_coord(y), canon_coord(z)};
      r = '0;
      if (position_of.exists(k)) begin
        r.vertex_index = vdi_pkg::vidx_t'(position_of[k] + 1);
      end else if (welded_count < vdi_pkg::TABLE_DEPTH) begin
        welded_keys[welded_count] = k;
        position_of[k] = welded_count;
        welded_count++;
        r.vertex_index = vdi_pkg::vidx_t'(welded_count);
        r.is_new = 1'b1;
      end else begin
        r.overflow = 1'b1;
      end
      r.corner_slot = next_slot;
      r.face_done   = (next_slot == vdi_pkg::SLOT_LAST);
      next_slot     = (next_slot == vdi_pkg::SLOT_LAST) ? vdi_pkg::SLOT_FIRST
                                                        : next_slot + vdi_pkg::slot_t'(1);
      expected_corners = {expected_corners, r};
    endfunction

    function void check_corner(corner_result_t got);
      corner_result_t want;
      if (expected_corners.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
          $display("ERROR: result with no corner outstanding: idx=%0d new=%0b slot=%0d",
                   got.vertex_index, got.is_new, got.corner_slot);
        end
        return;
      end
      want = expected_corners.pop_front();
      if (got.vertex_index !== want.vertex_index || got.is_new !== want.is_new ||
          got.corner_slot !== want.corner_slot || got.face_done !== want.face_done ||
          got.overflow !== want.overflow) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
          $display("ERROR: expected idx=%0d new=%0b slot=%0d done=%0b ovf=%0b",
                   want.vertex_index, want.is_new, want.corner_slot, want.face_done,
                   want.overflow);
          $display("       actual   idx=%0d new=%0b slot=%0d done=%0b ovf=%0b",
                   got.vertex_index, got.is_new, got.corner_slot, got.face_done,
                   got.overflow);
        end
      end
    endfunction
  endclass

  logic            clk;
  logic            rst_n;
  logic            in_valid;
  logic            in_stall;
  vdi_pkg::coord_t in_vertex_x;
  vdi_pkg::coord_t in_vertex_y;
  vdi_pkg::coord_t in_vertex_z;
  logic            out_valid;
  logic            out_stall;
  vdi_pkg::vidx_t  out_vertex_index;
  logic            out_is_new;
  vdi_pkg::slot_t  out_corner_slot;
  logic            out_face_done;
  logic            out_overflow;

  logic            tx_idle_on;
  logic            rx_idle_on;
  logic            rx_hold_req;

  vertex_weld_tracker tracker;

  vertex_dedup_indexer u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_vertex_x      (in_vertex_x),
    .in_vertex_y      (in_vertex_y),
    .in_vertex_z      (in_vertex_z),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_vertex_index (out_vertex_index),
    .out_is_new       (out_is_new),
    .out_corner_slot  (out_corner_slot),
    .out_face_done    (out_face_done),
    .out_overflow     (out_overflow)
  );

  initial clk = 1'b0;
  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  initial begin
    #(2 * CLK_HALF * TIMEOUT_CYCLES);
    $display("** vertex_dedup_indexer: FAILED **");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      tracker.check_corner({out_vertex_index, out_is_new, out_corner_slot, out_face_done,
                            out_overflow});
    end
  end

  // The receiver reads its requests at the rising edge and drives out_stall at the falling one.
  initial begin
    logic hold_taken;
    hold_taken = 1'b0;
    out_stall  = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (rx_hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        @(negedge clk);
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall = 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
        @(negedge clk);
        out_stall = 1'b1;
        repeat ($urandom_range(1, 19)) @(negedge clk);
        out_stall = 1'b0;
      end
    end
  end

  task automatic send_corner(input vdi_pkg::coord_t x, input vdi_pkg::coord_t y,
                             input vdi_pkg::coord_t z);
    if (tx_idle_on && $urandom_range(0, 7) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    in_vertex_x = x;
    in_vertex_y = y;
    in_vertex_z = z;
    in_valid    = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.note_corner(x, y, z);
    @(negedge clk);
  endtask

  task automatic send_random_corner(input int unsigned new_pct);
    vdi_pkg::coord_t c[3];
    vdi_pkg::key_t   k;
    int unsigned     pick;
    if (tracker.welded_count == 0 || $urandom_range(0, 99) < new_pct) begin
      for (int i = 0; i < 3; i++) begin
        case ($urandom_range(0, 15))
          0:       c[i] = vdi_pkg::coord_t'(0);
          1:       c[i] = vdi_pkg::NEG_ZERO;
          2:       c[i] = QUIET_NAN;
          3:       c[i] = ALL_ONES;
          default: c[i] = vdi_pkg::coord_t'($urandom);
        endcase
      end
    end else begin
      pick = $urandom_range(0, tracker.welded_count - 1);
      k    = tracker.welded_keys[pick];
      c[0] = k[3*vdi_pkg::COORD_W-1:2*vdi_pkg::COORD_W];
      c[1] = k[2*vdi_pkg::COORD_W-1:vdi_pkg::COORD_W];
      c[2] = k[vdi_pkg::COORD_W-1:0];
      for (int i = 0; i < 3; i++) begin
        if (c[i] == vdi_pkg::coord_t'(0) && $urandom_range(0, 1) == 1) begin
          c[i] = vdi_pkg::NEG_ZERO;
        end
      end
    end
    send_corner(c[0], c[1], c[2]);
  endtask

  task automatic drain_results();
    in_valid = 1'b0;
    while (tracker.expected_corners.size() != 0) @(negedge clk);
  endtask

  initial begin
    int unsigned sent;
    tracker     = new();
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_vertex_x = '0;
    in_vertex_y = '0;
    in_vertex_z = '0;
    tx_idle_on  = 1'b1;
    rx_idle_on  = 1'b1;
    rx_hold_req = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Zero folding, NaN patterns, all-ones and keys that differ in one coordinate only.
    send_corner('0, '0, '0);
    send_corner(vdi_pkg::NEG_ZERO, '0, '0);
    send_corner('0, vdi_pkg::NEG_ZERO, vdi_pkg::NEG_ZERO);
    send_corner(vdi_pkg::NEG_ZERO, vdi_pkg::NEG_ZERO, vdi_pkg::NEG_ZERO);
    send_corner(32'h8000_0001, '0, '0);
    send_corner(ALL_ONES, ALL_ONES, ALL_ONES);
    send_corner(QUIET_NAN, QUIET_NAN, QUIET_NAN);
    send_corner(QUIET_NAN, QUIET_NAN, QUIET_NAN);
    send_corner(32'hFFC0_0001, '0, '0);
    send_corner(ONE_F, '0, '0);
    send_corner('0, ONE_F, '0);
    send_corner('0, '0, ONE_F);
    send_corner(ONE_F, vdi_pkg::NEG_ZERO, '0);
    send_corner(32'h7FFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFE);
    send_corner(ALL_ONES, ALL_ONES, ALL_ONES);
    send_corner(vdi_pkg::NEG_ZERO, ONE_F, vdi_pkg::NEG_ZERO);
    send_corner(32'h0000_0001, 32'h8000_0000, 32'h7F80_0000);
    drain_results();

    // Fill the table, then keep going so that new corners overflow.
    sent = 0;
    while (tracker.welded_count < vdi_pkg::TABLE_DEPTH) begin
      if (sent == HOLD_AT_ITEM) begin
        rx_hold_req = 1'b1;
      end
      send_random_corner(FILL_NEW_PCT);
      sent++;
    end
    repeat (TAIL_ITEMS) send_random_corner(FULL_NEW_PCT);
    drain_results();

    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    repeat (TAIL_ITEMS) send_random_corner(FULL_NEW_PCT);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (tracker.mismatch_count == 0 && tracker.expected_corners.size() == 0) begin
      $display("** vertex_dedup_indexer: PASSED **");
    end else begin
      $display("** vertex_dedup_indexer: FAILED **");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/vdi_pkg.sv
hw/rtl/vdi_cell.sv
hw/rtl/vertex_dedup_indexer.sv
hw/rtl/vdi_checker.sv
tb/sv/tb_vertex_dedup_indexer.sv
